FILE: hdl/dad_pkg.sv
`timescale 1ns / 1ps

package dad_pkg;

    localparam int COORD_BITS   = 16;
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int MAG_BITS     = COORD_BITS;
    localparam int NUM_BOUNDS   = 45;
    localparam int CNT_BITS     = 6;
    localparam int SEARCH_STEPS = CNT_BITS;
    localparam int TAB_DEPTH    = 2 ** CNT_BITS;
    localparam int TAN_FRAC     = 48;
    localparam int TAN_BITS     = TAN_FRAC + 1;
    localparam int PROD_BITS    = MAG_BITS + TAN_BITS;
    localparam int ANGLE_BITS   = 9;

    localparam logic [ANGLE_BITS-1:0] DEG_0   = ANGLE_BITS'(0);
    localparam logic [ANGLE_BITS-1:0] DEG_90  = ANGLE_BITS'(90);
    localparam logic [ANGLE_BITS-1:0] DEG_180 = ANGLE_BITS'(180);
    localparam logic [ANGLE_BITS-1:0] DEG_270 = ANGLE_BITS'(270);
    localparam logic [ANGLE_BITS-1:0] DEG_360 = ANGLE_BITS'(360);

    localparam real PI_VAL = 3.14159265358979323846;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] from_x;
        logic signed [COORD_BITS-1:0] from_y;
        logic signed [COORD_BITS-1:0] to_x;
        logic signed [COORD_BITS-1:0] to_y;
    } t_in_beat;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] angle_degrees;
        logic                  same_points;
    } t_out_beat;

    typedef struct packed {
        logic same;
        logic x_neg;
        logic y_neg;
        logic x_zero;
        logic y_zero;
        logic swap;
    } t_quad;

    typedef struct packed {
        logic [MAG_BITS-1:0] num;
        logic [MAG_BITS-1:0] den;
        t_quad               quad;
    } t_oct;

    typedef struct packed {
        logic [CNT_BITS-1:0] cnt;
        t_quad               quad;
    } t_res;

    typedef logic [TAN_BITS-1:0] t_tan_table [TAB_DEPTH];

    // tan of the half-degree rounding boundaries, unused slots saturate at 1.0
    function automatic t_tan_table build_tan_table();
        t_tan_table tbl;
        real        b;
        for (int k = 0; k < TAB_DEPTH; k++) begin
            if (k < NUM_BOUNDS) begin
                b      = real'(2 * k + 1) * PI_VAL / 360.0;
                tbl[k] = TAN_BITS'(longint'($tan(b) * (2.0 ** TAN_FRAC)));
            end else begin
                tbl[k] = {1'b1, {TAN_FRAC{1'b0}}};
            end
        end
        return tbl;
    endfunction

    localparam t_tan_table TAN_TABLE = build_tan_table();

endpackage

FILE: hdl/direction_angle_degrees.sv
// Direction from a first point to a second point in whole degrees, 0..360.
// Input channel: i_in_valid / o_in_stall carry one beat of four signed Q12.4
// coordinates; a beat is taken on an edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid / i_out_stall carry one beat of angle_degrees and
// same_points; it is taken on an edge with o_out_valid high and i_out_stall low.
// Pipeline: two prep stages, six compare stages and one output register lie between
// an input beat and its result.
// Throughput: one beat per cycle while the receiver does not stall; each of the six
// compare stages does one 16 x 49 multiply against a constant tangent table and one compare.
// Reset (i_rst_n low, synchronous) empties every stage and the input skid slot;
// no stale result is presented afterwards.
// When the receiver stalls a valid result, the whole pipeline holds; a beat
// offered in that cycle is parked in a one-entry skid slot and o_in_stall rises
// on the next cycle until the slot drains.
// Equal points give same_points = 1 and angle 0.
`timescale 1ns / 1ps

module direction_angle_degrees (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  dad_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output dad_pkg::t_out_beat o_out_beat
);

    logic              r_skid_valid;
    dad_pkg::t_in_beat r_skid_beat;
    logic              w_accept;
    logic              w_en;
    logic              w_src_valid;
    dad_pkg::t_in_beat w_src_beat;

    logic              w_oct_valid;
    dad_pkg::t_oct     w_oct;
    logic              w_res_valid;
    dad_pkg::t_res     w_res;

    assign o_in_stall  = r_skid_valid;
    assign w_accept    = i_in_valid && !r_skid_valid;
    assign w_en        = !(o_out_valid && i_out_stall);
    assign w_src_valid = r_skid_valid || w_accept;
    assign w_src_beat  = r_skid_valid ? r_skid_beat : i_in_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (w_en) begin
            r_skid_valid <= 1'b0;
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_en && w_accept) begin
            r_skid_beat <= i_in_beat;
        end
    end

    dad_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_src_valid),
        .i_beat  (w_src_beat),
        .o_valid (w_oct_valid),
        .o_oct   (w_oct)
    );

    dad_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_oct_valid),
        .i_oct   (w_oct),
        .o_valid (w_res_valid),
        .o_res   (w_res)
    );

    dad_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_res_valid),
        .i_res   (w_res),
        .o_valid (o_out_valid),
        .o_beat  (o_out_beat)
    );

endmodule

FILE: hdl/dad_prep.sv
`timescale 1ns / 1ps

module dad_prep (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  dad_pkg::t_in_beat i_beat,
    output logic              o_valid,
    output dad_pkg::t_oct     o_oct
);

    logic                          r_a_valid;
    logic [dad_pkg::DIFF_BITS-1:0] r_dx;
    logic [dad_pkg::DIFF_BITS-1:0] r_dy;
    logic [dad_pkg::DIFF_BITS-1:0] n_dx;
    logic [dad_pkg::DIFF_BITS-1:0] n_dy;

    logic                          r_b_valid;
    dad_pkg::t_oct                 r_oct;
    dad_pkg::t_oct                 n_oct;
    logic [dad_pkg::DIFF_BITS-1:0] w_ax_full;
    logic [dad_pkg::DIFF_BITS-1:0] w_ay_full;
    logic [dad_pkg::MAG_BITS-1:0]  w_ax;
    logic [dad_pkg::MAG_BITS-1:0]  w_ay;

    always_comb begin
        n_dx = {i_beat.to_x[dad_pkg::COORD_BITS-1], i_beat.to_x}
             - {i_beat.from_x[dad_pkg::COORD_BITS-1], i_beat.from_x};
        n_dy = {i_beat.to_y[dad_pkg::COORD_BITS-1], i_beat.to_y}
             - {i_beat.from_y[dad_pkg::COORD_BITS-1], i_beat.from_y};
    end

    always_comb begin
        w_ax_full = r_dx[dad_pkg::DIFF_BITS-1] ? (~r_dx + 1'b1) : r_dx;
        w_ay_full = r_dy[dad_pkg::DIFF_BITS-1] ? (~r_dy + 1'b1) : r_dy;
        w_ax      = w_ax_full[dad_pkg::MAG_BITS-1:0];
        w_ay      = w_ay_full[dad_pkg::MAG_BITS-1:0];

        n_oct.quad.x_neg  = r_dx[dad_pkg::DIFF_BITS-1];
        n_oct.quad.y_neg  = r_dy[dad_pkg::DIFF_BITS-1];
        n_oct.quad.x_zero = (r_dx == '0);
        n_oct.quad.y_zero = (r_dy == '0);
        n_oct.quad.same   = (r_dx == '0) && (r_dy == '0);
        n_oct.quad.swap   = (w_ay > w_ax);
        // fold into the lower octant: num <= den
        n_oct.num = (w_ay > w_ax) ? w_ax : w_ay;
        n_oct.den = (w_ay > w_ax) ? w_ay : w_ax;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx  <= n_dx;
            r_dy  <= n_dy;
            r_oct <= n_oct;
        end
    end

    assign o_valid = r_b_valid;
    assign o_oct   = r_oct;

endmodule

FILE: hdl/dad_search.sv
`timescale 1ns / 1ps

module dad_search (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  dad_pkg::t_oct i_oct,
    output logic          o_valid,
    output dad_pkg::t_res o_res
);

    logic                          r_valid [dad_pkg::SEARCH_STEPS];
    logic [dad_pkg::MAG_BITS-1:0]  r_num   [dad_pkg::SEARCH_STEPS];
    logic [dad_pkg::MAG_BITS-1:0]  r_den   [dad_pkg::SEARCH_STEPS];
    logic [dad_pkg::CNT_BITS-1:0]  r_cnt   [dad_pkg::SEARCH_STEPS];
    dad_pkg::t_quad                r_quad  [dad_pkg::SEARCH_STEPS];

    logic                          w_in_valid [dad_pkg::SEARCH_STEPS];
    logic [dad_pkg::MAG_BITS-1:0]  w_in_num   [dad_pkg::SEARCH_STEPS];
    logic [dad_pkg::MAG_BITS-1:0]  w_in_den   [dad_pkg::SEARCH_STEPS];
    logic [dad_pkg::CNT_BITS-1:0]  w_in_cnt   [dad_pkg::SEARCH_STEPS];
    dad_pkg::t_quad                w_in_quad  [dad_pkg::SEARCH_STEPS];

    logic [dad_pkg::CNT_BITS-1:0]  w_step [dad_pkg::SEARCH_STEPS];
    logic [dad_pkg::CNT_BITS-1:0]  w_idx  [dad_pkg::SEARCH_STEPS];
    logic [dad_pkg::PROD_BITS-1:0] w_prod [dad_pkg::SEARCH_STEPS];
    logic [dad_pkg::PROD_BITS-1:0] w_lhs  [dad_pkg::SEARCH_STEPS];
    logic [dad_pkg::CNT_BITS-1:0]  n_cnt  [dad_pkg::SEARCH_STEPS];

    always_comb begin
        w_in_valid[0] = i_valid;
        w_in_num[0]   = i_oct.num;
        w_in_den[0]   = i_oct.den;
        w_in_cnt[0]   = '0;
        w_in_quad[0]  = i_oct.quad;
        for (int s = 1; s < dad_pkg::SEARCH_STEPS; s++) begin
            w_in_valid[s] = r_valid[s-1];
            w_in_num[s]   = r_num[s-1];
            w_in_den[s]   = r_den[s-1];
            w_in_cnt[s]   = r_cnt[s-1];
            w_in_quad[s]  = r_quad[s-1];
        end
    end

    // one bit of the boundary count per stage: num * 2^F > den * tan(boundary)
    always_comb begin
        for (int s = 0; s < dad_pkg::SEARCH_STEPS; s++) begin
            w_step[s] = dad_pkg::CNT_BITS'(1 << (dad_pkg::SEARCH_STEPS - 1 - s));
            w_idx[s]  = dad_pkg::CNT_BITS'(w_in_cnt[s] + w_step[s] - 1'b1);
            w_prod[s] = w_in_den[s] * dad_pkg::TAN_TABLE[w_idx[s]];
            w_lhs[s]  = {1'b0, w_in_num[s], {dad_pkg::TAN_FRAC{1'b0}}};
            n_cnt[s]  = (w_lhs[s] > w_prod[s])
                      ? dad_pkg::CNT_BITS'(w_in_cnt[s] + w_step[s])
                      : w_in_cnt[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < dad_pkg::SEARCH_STEPS; s++) begin
                r_valid[s] <= 1'b0;
            end
        end else if (i_en) begin
            for (int s = 0; s < dad_pkg::SEARCH_STEPS; s++) begin
                r_valid[s] <= w_in_valid[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < dad_pkg::SEARCH_STEPS; s++) begin
                r_num[s]  <= w_in_num[s];
                r_den[s]  <= w_in_den[s];
                r_cnt[s]  <= n_cnt[s];
                r_quad[s] <= w_in_quad[s];
            end
        end
    end

    assign o_valid    = r_valid[dad_pkg::SEARCH_STEPS-1];
    assign o_res.cnt  = r_cnt[dad_pkg::SEARCH_STEPS-1];
    assign o_res.quad = r_quad[dad_pkg::SEARCH_STEPS-1];

endmodule

FILE: hdl/dad_map.sv
`timescale 1ns / 1ps

module dad_map (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  dad_pkg::t_res      i_res,
    output logic               o_valid,
    output dad_pkg::t_out_beat o_beat
);

    logic                           r_valid;
    dad_pkg::t_out_beat             r_beat;
    dad_pkg::t_out_beat             n_beat;
    logic [dad_pkg::ANGLE_BITS-1:0] w_cnt;
    logic [dad_pkg::ANGLE_BITS-1:0] w_r;

    always_comb begin
        w_cnt = dad_pkg::ANGLE_BITS'(i_res.cnt);
        w_r   = i_res.quad.swap ? (dad_pkg::DEG_90 - w_cnt) : w_cnt;

        n_beat.same_points = i_res.quad.same;
        if (i_res.quad.same) begin
            n_beat.angle_degrees = dad_pkg::DEG_0;
        end else if (i_res.quad.y_zero) begin
            n_beat.angle_degrees = i_res.quad.x_neg ? dad_pkg::DEG_180 : dad_pkg::DEG_0;
        end else if (i_res.quad.x_zero) begin
            n_beat.angle_degrees = i_res.quad.y_neg ? dad_pkg::DEG_270 : dad_pkg::DEG_90;
        end else if (!i_res.quad.y_neg) begin
            n_beat.angle_degrees = i_res.quad.x_neg ? (dad_pkg::DEG_180 - w_r) : w_r;
        end else begin
            n_beat.angle_degrees = i_res.quad.x_neg ? (dad_pkg::DEG_180 + w_r)
                                                    : (dad_pkg::DEG_360 - w_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

FILE: hdl/dad_checker.sv
`timescale 1ns / 1ps

module dad_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input dad_pkg::t_in_beat  i_in_beat,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input dad_pkg::t_out_beat o_out_beat
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("stalled output beat changed");

    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid && o_out_valid && i_out_stall))
        else $error("input stall raised without a parked beat");

    a_same_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.same_points |-> o_out_beat.angle_degrees == '0)
        else $error("coincident points with nonzero angle");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_beat.angle_degrees <= dad_pkg::DEG_360)
        else $error("angle above 360");

endmodule

bind direction_angle_degrees dad_checker u_checker (.*);

FILE: sim/direction_angle_degrees_test.sv
`timescale 1ns / 1ps

module direction_angle_degrees_test;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SQUEEZE_CYCLES = 60;
    localparam int DRAIN_CYCLES   = 24;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    dad_pkg::t_in_beat  i_in_beat = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    dad_pkg::t_out_beat o_out_beat;

    dad_pkg::t_in_beat  pending_pairs [$];
    dad_pkg::t_out_beat expected_headings [$];
    logic [63:0]        sin_bound [dad_pkg::NUM_BOUNDS];
    logic [63:0]        cos_bound [dad_pkg::NUM_BOUNDS];

    int   n_queued = 0;
    int   n_taken = 0;
    int   fault_count = 0;
    int   quiet_cycles = 0;
    int   gap_left = 0;
    int   hold_left = 0;
    int   squeeze_req = 0;
    int   squeeze_seen = 0;
    logic idle_on = 1'b0;
    logic beat_taken = 1'b0;

    direction_angle_degrees DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [63:0] mul_hi64(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[127:64];
    endfunction

    // m * pi / 360 as Q0.64, from pi held to 128 bits
    function automatic logic [63:0] half_deg_rad(int m);
        logic [31:0] pi_w [4];
        logic [63:0] q [4];
        logic [63:0] rem, cur, p, carry;
        pi_w[0] = 32'hC90FDAA2;
        pi_w[1] = 32'h2168C234;
        pi_w[2] = 32'hC4C6628B;
        pi_w[3] = 32'h80DC1CD1;
        rem = 64'd0;
        carry = 64'd0;
        for (int i = 0; i < 4; i++) begin
            cur = (rem << 32) | {32'd0, pi_w[i]};
            q[i] = cur / 64'd90;
            rem = cur % 64'd90;
        end
        for (int i = 3; i >= 0; i--) begin
            p = q[i] * 64'(m) + carry;
            q[i] = p & 64'hFFFF_FFFF;
            carry = p >> 32;
        end
        return (q[0] << 32) | q[1];
    endfunction

    function automatic void build_bound_trig();
        logic [63:0] x, x2, t, s, tc, c;
        int          n;
        for (int k = 0; k < dad_pkg::NUM_BOUNDS; k++) begin
            x = half_deg_rad(2 * k + 1);
            x2 = mul_hi64(x, x);
            t = x;
            s = x;
            for (n = 1; n < 24 && t != 64'd0; n++) begin
                t = mul_hi64(t, x2) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    s = s - t;
                else
                    s = s + t;
            end
            tc = x2 / 64'd2;
            c = tc;
            for (n = 1; n < 24 && tc != 64'd0; n++) begin
                tc = mul_hi64(tc, x2) / 64'((2 * n + 1) * (2 * n + 2));
                if (n % 2 == 1)
                    c = c - tc;
                else
                    c = c + tc;
            end
            sin_bound[k] = s;
            cos_bound[k] = 64'd0 - c;
        end
    endfunction

    // count half-degree boundaries that lie below atan(num / den)
    function automatic int bounds_below(logic [63:0] num, logic [63:0] den);
        logic [127:0] lhs, rhs;
        int           cnt;
        cnt = 0;
        for (int k = 0; k < dad_pkg::NUM_BOUNDS; k++) begin
            lhs = {64'd0, num} * {64'd0, cos_bound[k]};
            rhs = {64'd0, den} * {64'd0, sin_bound[k]};
            if (lhs > rhs)
                cnt++;
        end
        return cnt;
    endfunction

    function automatic dad_pkg::t_out_beat heading_of(dad_pkg::t_in_beat b);
        dad_pkg::t_out_beat res;
        longint             dx, dy;
        logic [63:0]        ax, ay;
        int                 r, ang;
        dx = longint'($signed(b.to_x)) - longint'($signed(b.from_x));
        dy = longint'($signed(b.to_y)) - longint'($signed(b.from_y));
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        res.same_points = 1'b0;
        if (dx == 0 && dy == 0) begin
            ang = 0;
            res.same_points = 1'b1;
        end else if (dy == 0) begin
            ang = (dx > 0) ? 0 : 180;
        end else if (dx == 0) begin
            ang = (dy > 0) ? 90 : 270;
        end else begin
            if (ay <= ax)
                r = bounds_below(ay, ax);
            else
                r = 90 - bounds_below(ax, ay);
            if (dy > 0)
                ang = (dx > 0) ? r : 180 - r;
            else
                ang = (dx > 0) ? 360 - r : 180 + r;
        end
        res.angle_degrees = dad_pkg::ANGLE_BITS'(ang);
        return res;
    endfunction

    function automatic dad_pkg::t_in_beat pair_of(int fx, int fy, int tx, int ty);
        dad_pkg::t_in_beat b;
        b.from_x = dad_pkg::COORD_BITS'(fx);
        b.from_y = dad_pkg::COORD_BITS'(fy);
        b.to_x   = dad_pkg::COORD_BITS'(tx);
        b.to_y   = dad_pkg::COORD_BITS'(ty);
        return b;
    endfunction

    function automatic int edge_coord();
        case ($urandom_range(0, 4))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    function automatic dad_pkg::t_in_beat random_pair();
        dad_pkg::t_in_beat b;
        int                d;
        b = pair_of($urandom, $urandom, $urandom, $urandom);
        case ($urandom_range(0, 11))
            3: begin
                b.to_x = b.from_x;
                b.to_y = b.from_y;
            end
            4: b.to_x = b.from_x;
            5: b.to_y = b.from_y;
            6, 7: begin
                b.to_x = dad_pkg::COORD_BITS'(int'(b.from_x) + $urandom_range(0, 64) - 32);
                b.to_y = dad_pkg::COORD_BITS'(int'(b.from_y) + $urandom_range(0, 64) - 32);
            end
            8: begin
                d = $urandom_range(1, 2000);
                b.to_x = dad_pkg::COORD_BITS'(int'(b.from_x)
                                              + ($urandom_range(0, 1) ? d : -d));
                b.to_y = dad_pkg::COORD_BITS'(int'(b.from_y)
                                              + ($urandom_range(0, 1) ? d : -d));
            end
            9: begin
                b.to_x = dad_pkg::COORD_BITS'(int'(b.from_x)
                                              + $urandom_range(0, 8000) - 4000);
                b.to_y = dad_pkg::COORD_BITS'(int'(b.from_y) + $urandom_range(0, 6) - 3);
            end
            10: b = pair_of(edge_coord(), edge_coord(), edge_coord(), edge_coord());
            default: ;
        endcase
        return b;
    endfunction

    task automatic add_pair(dad_pkg::t_in_beat b);
        pending_pairs.push_back(b);
        n_queued++;
    endtask

    task automatic add_random_pairs(int count);
        for (int i = 0; i < count; i++)
            add_pair(random_pair());
    endtask

    task automatic drain_inputs();
        while (n_taken < n_queued)
            @(posedge i_clk);
    endtask

    task automatic log_fault(string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%s", msg);
    endtask

    // sender: hold a stalled beat, otherwise advance or idle
    always @(negedge i_clk) begin
        dad_pkg::t_in_beat nb;
        logic              nv;
        nb = i_in_beat;
        nv = i_in_valid;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else if (!i_in_valid || beat_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                nv = 1'b0;
            end else if (idle_on && pending_pairs.size() != 0
                         && $urandom_range(0, 3) == 0) begin
                gap_left = $urandom_range(1, 9) - 1;
                nv = 1'b0;
            end else if (pending_pairs.size() != 0) begin
                nb = pending_pairs.pop_front();
                nv = 1'b1;
            end else begin
                nv = 1'b0;
            end
        end
        i_in_valid <= nv;
        i_in_beat <= nb;
    end

    // receiver: random stall bursts, one long hold per squeeze request
    always @(negedge i_clk) begin
        if (squeeze_req != squeeze_seen) begin
            squeeze_seen = squeeze_req;
            hold_left = SQUEEZE_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            hold_left = $urandom_range(1, 9) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        dad_pkg::t_out_beat want;
        beat_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (beat_taken) begin
            expected_headings.push_back(heading_of(i_in_beat));
            n_taken++;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_headings.size() == 0) begin
                log_fault($sformatf("unexpected beat at %0t: angle %0d same %0b",
                                    $time, o_out_beat.angle_degrees,
                                    o_out_beat.same_points));
            end else begin
                want = expected_headings.pop_front();
                if (o_out_beat.angle_degrees !== want.angle_degrees
                    || o_out_beat.same_points !== want.same_points)
                    log_fault($sformatf(
                        "wrong beat at %0t: expected angle %0d same %0b, got angle %0d same %0b",
                        $time, want.angle_degrees, want.same_points,
                        o_out_beat.angle_degrees, o_out_beat.same_points));
            end
        end
    end

    always @(posedge i_clk) begin
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else if (!i_rst_n || (i_in_valid && !o_in_stall)
                     || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        build_bound_trig();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_pair(pair_of(0, 0, 0, 0));
        add_pair(pair_of(-32768, 32767, -32768, 32767));
        add_pair(pair_of(100, 50, 900, 50));
        add_pair(pair_of(100, 50, -900, 50));
        add_pair(pair_of(100, 50, 100, 700));
        add_pair(pair_of(100, 50, 100, -700));
        add_pair(pair_of(-32768, -32768, 32767, 32767));
        add_pair(pair_of(32767, 32767, -32768, -32768));
        add_pair(pair_of(32767, -32768, -32768, 32767));
        add_pair(pair_of(-32768, 32767, 32767, -32768));
        add_pair(pair_of(-32768, 0, 32767, -1));
        add_pair(pair_of(-32768, 0, 32767, 1));
        add_pair(pair_of(32767, 0, -32768, 1));
        add_pair(pair_of(32767, 0, -32768, -1));
        add_pair(pair_of(0, -32768, 1, 32767));
        add_pair(pair_of(0, 32767, -1, -32768));
        add_pair(pair_of(0, 0, 2, 1));
        add_pair(pair_of(0, 0, -1, 2));
        add_pair(pair_of(0, 0, -3, -1));
        add_pair(pair_of(0, 0, 1, -3));
        add_pair(pair_of(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555));
        add_pair(pair_of(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA));
        add_pair(pair_of(-1, -1, 0, 0));

        idle_on = 1'b1;
        add_random_pairs(330);
        drain_inputs();

        idle_on = 1'b0;
        squeeze_req++;
        add_random_pairs(120);
        drain_inputs();

        idle_on = 1'b1;
        add_random_pairs(300);
        drain_inputs();

        idle_on = 1'b0;
        add_random_pairs(100);
        drain_inputs();

        while (expected_headings.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fault_count == 0 && expected_headings.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/dad_pkg.sv
hdl/dad_prep.sv
hdl/dad_search.sv
hdl/dad_map.sv
hdl/direction_angle_degrees.sv
hdl/dad_checker.sv
sim/direction_angle_degrees_test.sv
